[rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int unsigned MaxPagesDefault = 65536;
  localparam int unsigned PageShift       = 12;
  localparam int unsigned WordBits        = 64;
  localparam int unsigned WordShift       = 6;

  localparam logic [2:0] ModeAlloc   = 3'd0;
  localparam logic [2:0] ModeFree    = 3'd1;
  localparam logic [2:0] ModeQuery   = 3'd2;
  localparam logic [2:0] ModeStats   = 3'd3;
  localparam logic [2:0] ModeReserve = 3'd4;

  localparam logic [1:0] StatusDone   = 2'd0;
  localparam logic [1:0] StatusNoRun  = 2'd1;
  localparam logic [1:0] StatusZeroCt = 2'd2;

  localparam logic [0:0] CfgRegionBase = 1'b0;
  localparam logic [0:0] CfgPageCount  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StScanRd,
    StScanWt,
    StScan,
    StMarkRd,
    StMarkWt,
    StMark,
    StRmwRd,
    StRmwWt,
    StRmw,
    StQueryRd,
    StQueryWt,
    StDone
  } state_e;

endpackage

[rtl/bitmap_page_allocator_core.sv]
// First-fit page bitmap allocator. One used bit per 4096-byte page is kept in a
// 64-bit-wide single-port memory. After reset a clearing pass zeroes every word
// of the memory before the first item is taken. Items are handled one at a
// time. Allocate scans one bit per cycle from page 0, pausing to read each new
// word, then marks the pages of the run it finds, reading each word it touches.
// Free and reserve visit one page at a time through a read-modify-write of its
// word; statistics read the word of each window page in turn to count used
// bits. A query reads the word of its page. Every item ends in a done state
// that loads the result into the output register. The next item can be
// accepted while a result waits to be taken; a finished item is held until the
// output register is free.
module bitmap_page_allocator_core #(
  parameter int unsigned PAGE_LIMIT = bpa_pkg::MaxPagesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [63:0] address_i,
  input  logic [16:0] count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_address_o,
  output logic [1:0]  status_o,
  output logic        page_is_free_o,
  output logic [16:0] free_count_o,
  output logic [16:0] used_count_o,
  output logic [31:0] alloc_total_o,
  output logic [31:0] fail_total_o
);
  import bpa_pkg::*;

  localparam int unsigned IdxW   = $clog2(PAGE_LIMIT);
  localparam int unsigned Words  = (PAGE_LIMIT + WordBits - 1) / WordBits;
  localparam int unsigned WAddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CntW   = (IdxW + 1 > WordShift + WAddrW) ? IdxW + 1
                                                                  : WordShift + WAddrW;

  function automatic logic [WAddrW-1:0] word_of(logic [CntW-1:0] p);
    return p[WordShift +: WAddrW];
  endfunction

  logic [WordBits-1:0] mem_q [Words];
  logic [WordBits-1:0] rdata_q;
  logic [WordBits-1:0] wdata;
  logic [WAddrW-1:0]   waddr;
  logic [WAddrW-1:0]   raddr;
  logic                mem_we;

  state_e state_q, state_d;

  logic [63:0] base_q;
  logic [16:0] pcount_q;
  logic [2:0]  mode_q;
  logic [63:0] addr_q;
  logic [16:0] count_q;
  logic [CntW-1:0] idx_q, idx_d;      // current page
  logic [CntW-1:0] stop_q, stop_d;    // exclusive end page
  logic [CntW-1:0] start_q, start_d;  // run start
  logic [16:0] run_q, run_d;
  logic [16:0] step_q, step_d;        // free pages visited
  logic [CntW-1:0] used_q, used_d;
  logic [31:0] alloc_cnt_q, fail_cnt_q;
  logic [WAddrW-1:0] clr_q;

  logic [CntW-1:0] n_win;
  logic [63:0] fa;          // current free address
  logic [63:0] foff;
  logic        f_ok;
  logic        cur_bit;
  logic [WordShift-1:0] bitpos;
  logic        accept;
  logic        done_fire;

  assign n_win = (32'(pcount_q) > 32'(PAGE_LIMIT)) ? CntW'(PAGE_LIMIT) : CntW'(pcount_q);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign done_fire = (state_q == StDone) && !(out_valid_o && out_stall_i);
  assign bitpos = idx_q[WordShift-1:0];
  assign cur_bit = rdata_q[bitpos];

  // free address of step step_q
  assign fa   = addr_q + 64'({step_q, 12'b0});
  assign foff = fa - base_q;
  assign f_ok = (fa[PageShift-1:0] == '0) && (fa >= base_q)
             && (foff[63:PageShift] < 52'(n_win));

  // reserve range bounds
  logic [63:0] r_off, r_d, r_span, r_first, r_stop;
  always_comb begin
    r_off  = (address_i - base_q) >> PageShift;
    r_d    = base_q - address_i;
    r_span = {35'b0, count_i, 12'b0};
    if (address_i >= base_q) begin
      r_first = r_off;
      r_stop  = r_off + 64'(count_i);
    end else begin
      r_first = '0;
      r_stop  = (r_d >= r_span) ? 64'd0 : (r_span - r_d + 64'd4095) >> PageShift;
    end
    if (r_stop > 64'(n_win)) r_stop = 64'(n_win);
    if (r_first > r_stop) r_first = r_stop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= 64'd1048576;
      pcount_q <= 17'd65536;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgRegionBase) base_q <= cfg_data_i;
      else pcount_q <= cfg_data_i[16:0];
    end
  end

  // write-first: a word written this cycle is seen by the next read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wdata;
    rdata_q <= (mem_we && waddr == raddr) ? wdata : mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) begin
        unique case (mode_i)
          ModeAlloc:   state_d = (count_i == '0) ? StDone : StScanRd;
          ModeFree:    state_d = (count_i == '0) ? StDone : StRmwRd;
          ModeQuery:   state_d = StQueryRd;
          ModeStats:   state_d = (n_win == '0) ? StDone : StRmwRd;
          ModeReserve: state_d = (r_first == r_stop) ? StDone : StRmwRd;
          default:     state_d = StDone;
        endcase
      end
      StClear:   if (clr_q == WAddrW'(Words - 1)) state_d = StIdle;
      StScanRd:  state_d = (idx_q >= n_win) ? StDone : StScanWt;
      StScanWt:  state_d = StScan;
      StScan: begin
        if (!cur_bit && run_q + 17'd1 == count_q) state_d = StMarkRd;
        else if (idx_q + 1'b1 >= n_win) state_d = StDone;
        else if (bitpos == '1) state_d = StScanRd;
      end
      StMarkRd:  state_d = StMarkWt;
      StMarkWt:  state_d = StMark;
      StMark:    if (idx_q + 1'b1 == stop_q) state_d = StDone;
                 else if (bitpos == '1) state_d = StMarkRd;
      StRmwRd:   state_d = StRmwWt;
      StRmwWt:   state_d = StRmw;
      StRmw: begin
        if (mode_q == ModeFree) begin
          if (step_q + 17'd1 == count_q) state_d = StDone;
          else state_d = StRmwRd;
        end else if (idx_q + 1'b1 >= stop_q) state_d = StDone;
        else state_d = StRmwRd;
      end
      StQueryRd: state_d = StQueryWt;
      StQueryWt: state_d = StDone;
      StDone:    if (!(out_valid_o && out_stall_i)) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // page targeted by a free step
  logic [CntW-1:0] fidx;
  assign fidx = CntW'(foff[63:PageShift]);

  // query page lookup
  logic [63:0] q_off;
  logic        q_ok;
  logic [CntW-1:0] q_idx;
  assign q_off = addr_q - base_q;
  assign q_ok  = (addr_q[PageShift-1:0] == '0) && (addr_q >= base_q)
              && (q_off[63:PageShift] < 52'(n_win));
  assign q_idx = CntW'(q_off[63:PageShift]);

  always_comb begin
    mem_we = 1'b0;
    waddr  = clr_q;
    wdata  = rdata_q;
    raddr  = word_of(idx_q);
    idx_d = idx_q; stop_d = stop_q; start_d = start_q;
    run_d = run_q; step_d = step_q; used_d = used_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d = '0; run_d = '0; step_d = '0; used_d = '0;
          stop_d = n_win;
          if (mode_i == ModeReserve) begin
            idx_d  = CntW'(r_first);
            stop_d = CntW'(r_stop);
          end
        end
      end
      StClear: begin
        mem_we = 1'b1;
        wdata  = '0;
        raddr  = clr_q;
      end
      StScan: begin
        if (!cur_bit) begin
          if (run_q == '0) start_d = idx_q;
          run_d = run_q + 17'd1;
          if (run_q + 17'd1 == count_q) begin
            idx_d  = (run_q == '0) ? idx_q : start_q;
            stop_d = ((run_q == '0) ? idx_q : start_q) + CntW'(count_q);
          end else idx_d = idx_q + 1'b1;
        end else begin
          run_d = '0;
          idx_d = idx_q + 1'b1;
        end
      end
      StMark: begin
        mem_we = 1'b1;
        waddr  = word_of(idx_q);
        wdata[bitpos] = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      StRmwRd: begin
        if (mode_q == ModeFree) raddr = word_of(fidx);
      end
      StRmwWt: begin
        if (mode_q == ModeFree) raddr = word_of(fidx);
      end
      StRmw: begin
        if (mode_q == ModeFree) begin
          raddr = word_of(fidx);
          if (f_ok) begin
            mem_we = 1'b1;
            waddr  = word_of(fidx);
            wdata[fidx[WordShift-1:0]] = 1'b0;
          end
          step_d = step_q + 17'd1;
        end else if (mode_q == ModeReserve) begin
          mem_we = 1'b1;
          waddr  = word_of(idx_q);
          wdata[bitpos] = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          used_d = used_q + CntW'(cur_bit);
          idx_d  = idx_q + 1'b1;
        end
      end
      StQueryRd, StQueryWt: begin
        raddr = word_of(q_idx);
      end
      StDone: begin
        // keep the queried word while the result waits
        if (mode_q == ModeQuery) raddr = word_of(q_idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      alloc_cnt_q <= '0;
      fail_cnt_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (done_fire) begin
        out_valid_o <= 1'b1;
        if (mode_q == ModeAlloc && count_q != '0) begin
          if (run_q == count_q) alloc_cnt_q <= alloc_cnt_q + 32'd1;
          else fail_cnt_q <= fail_cnt_q + 32'd1;
        end
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; stop_q <= stop_d; start_q <= start_d;
    run_q <= run_d; step_q <= step_d; used_q <= used_d;
    if (accept) begin
      mode_q  <= mode_i;
      addr_q  <= address_i;
      count_q <= count_i;
    end
    if (done_fire) begin
      result_address_o <= '0;
      status_o         <= StatusDone;
      page_is_free_o   <= 1'b0;
      free_count_o     <= '0;
      used_count_o     <= '0;
      alloc_total_o    <= '0;
      fail_total_o     <= '0;
      unique case (mode_q)
        ModeAlloc: begin
          if (count_q == '0) status_o <= StatusZeroCt;
          else if (run_q == count_q)
            result_address_o <= base_q + {{(52-CntW){1'b0}}, start_q, 12'b0};
          else status_o <= StatusNoRun;
        end
        ModeQuery: page_is_free_o <= q_ok && !rdata_q[q_off[PageShift+WordShift-1:PageShift]];
        ModeStats: begin
          free_count_o  <= 17'(n_win - used_q);
          used_count_o  <= 17'(used_q);
          alloc_total_o <= alloc_cnt_q;
          fail_total_o  <= fail_cnt_q;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o)
    else $error("item accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> out_valid_o)
    else $error("finished item produced no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMark) |-> (idx_q < stop_q))
    else $error("marking past the run");
endmodule
